// ===== sv/video_frame_format_change_reporter_core_macros.svh =====
// Assertion macros for the format change reporter.
// Used by the front and back modules; no dependencies.
`ifndef VIDEO_FRAME_FORMAT_CHANGE_REPORTER_CORE_MACROS_SVH
`define VIDEO_FRAME_FORMAT_CHANGE_REPORTER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define VFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/vffcr_pkg.sv =====
// Shared types and constants for the format change reporter.
// No dependencies.
package vffcr_pkg;
  localparam int unsigned Channels = 4;
  localparam int unsigned ChW = $clog2(Channels);
  localparam logic [2:0] NoChannel = 3'd7;
  localparam logic [7:0] ModeReset = 8'd5;
  localparam logic [7:0] ModeHevcA = 8'd3;
  localparam logic [7:0] ModeTenBit = 8'd4;
  localparam logic [5:0] ErrRate = 6'd30;

  typedef struct packed {
    logic [1:0]  channel;
    logic [15:0] pic_width;
    logic [15:0] pic_height;
    logic [31:0] horiz_crop_word;
    logic [31:0] vert_crop_word;
    logic [31:0] rate_numerator;
    logic [31:0] rate_divisor;
    logic [7:0]  map_mode;
    logic signed [7:0] packing_code;
    logic [15:0] aspect_width;
    logic [15:0] aspect_height;
    logic        clock_live;
  } in_item_t;

  typedef struct packed {
    logic        format_changed;
    logic [15:0] crop_width;
    logic [15:0] crop_height;
    logic [5:0]  nominal_rate;
    logic        rate_error;
    logic        ten_bit;
    logic [2:0]  stereo_type;
    logic [31:0] vertical_offset;
    logic [31:0] aspect_word;
    logic        pts_channel;
  } out_item_t;

  // Classified job handed from front to back.
  typedef struct packed {
    logic        changed;
    logic        pts;
    logic [15:0] crop_width;
    logic [15:0] crop_height;
    logic [31:0] numerator;
    logic [31:0] divisor;
    logic        live;
    logic        ten_bit;
    logic [2:0]  stereo;
    logic [31:0] voffset;
    logic [31:0] aspect;
  } job_t;

  function automatic logic [5:0] snap_rate(input logic [41:0] mhz, input logic live,
                                           output logic err);
    logic [5:0] r;
    r = ErrRate;
    err = 1'b1;
    if (live) begin
      if (mhz <= 42'd23976) begin r = 6'd24; err = 1'b0; end
      else if (mhz <= 42'd24000) begin r = 6'd24; err = 1'b0; end
      else if (mhz <= 42'd25000) begin r = 6'd25; err = 1'b0; end
      else if (mhz <= 42'd30000) begin r = 6'd30; err = 1'b0; end
      else if (mhz <= 42'd50000) begin r = 6'd50; err = 1'b0; end
      else if (mhz <= 42'd60000) begin r = 6'd60; err = 1'b0; end
    end else begin
      if (mhz <= 42'd23988) begin r = 6'd23; err = 1'b0; end
      else if (mhz <= 42'd24500) begin r = 6'd24; err = 1'b0; end
      else if (mhz <= 42'd27485) begin r = 6'd25; err = 1'b0; end
      else if (mhz <= 42'd29985) begin r = 6'd29; err = 1'b0; end
      else if (mhz <= 42'd40000) begin r = 6'd30; err = 1'b0; end
      else if (mhz <= 42'd54970) begin r = 6'd50; err = 1'b0; end
      else if (mhz <= 42'd59970) begin r = 6'd59; err = 1'b0; end
      else if (mhz <= 42'd60000) begin r = 6'd60; err = 1'b0; end
    end
    return r;
  endfunction
endpackage

// ===== sv/vffcr_front.sv =====
// Front part: compares descriptors with per-channel state, tracks seamless
// switching and builds a job. Depends on vffcr_pkg.
`include "video_frame_format_change_reporter_core_macros.svh"
module vffcr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                seamless_i,
  input  logic                in_valid,
  output logic                in_ready,
  input  vffcr_pkg::in_item_t in_data,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output vffcr_pkg::job_t     job_o
);
  localparam int unsigned N = vffcr_pkg::Channels;
  localparam int unsigned W = vffcr_pkg::ChW;

  logic [15:0] wid_q [N];
  logic [15:0] hgt_q [N];
  logic [31:0] num_q [N];
  logic [31:0] div_q [N];
  logic [7:0]  mode_q [N];
  logic [7:0]  pack_q [N];
  logic [31:0] voff_q [N];
  logic [2:0]  prev_q, prev_d;
  logic [7:0]  dly_q, dly_d;
  logic        ts_q, ts_d;
  logic        sw;
  logic        job_valid_q;
  vffcr_pkg::job_t job_q, job_d;
  logic [W-1:0] idx;
  logic        diff;
  logic        take;
  logic [2:0]  chx;

  assign in_ready = !job_valid_q || job_ready_i;
  assign take = in_valid && in_ready;
  assign idx = W'(32'(in_data.channel) % N);
  assign chx = {1'b0, in_data.channel};

  always_comb begin
    prev_d = prev_q;
    dly_d = dly_q;
    ts_d = ts_q;
    sw = 1'b0;
    if (!seamless_i) begin
      prev_d = vffcr_pkg::NoChannel;
      dly_d = 8'd0;
    end else if (prev_q != chx) begin
      dly_d = dly_q + 8'd1;
      if (dly_d == 8'd1 && prev_q == 3'd1) begin
        prev_d = chx; dly_d = 8'd0; ts_d = 1'b0; sw = 1'b1;
      end
      if (dly_d == 8'd1 && prev_d == 3'd0) begin
        prev_d = chx; dly_d = 8'd0; ts_d = 1'b1; sw = 1'b1;
      end
      if (prev_d == vffcr_pkg::NoChannel && in_data.channel <= 2'd1) begin
        prev_d = chx; dly_d = 8'd0; ts_d = in_data.channel[0];
      end
    end
  end

  always_comb begin
    logic [15:0] lc, rc, tc, bc;
    lc = in_data.horiz_crop_word[31:16];
    rc = in_data.horiz_crop_word[15:0];
    tc = in_data.vert_crop_word[31:16];
    bc = in_data.vert_crop_word[15:0];
    diff = wid_q[idx] != in_data.pic_width || hgt_q[idx] != in_data.pic_height ||
           num_q[idx] != in_data.rate_numerator || div_q[idx] != in_data.rate_divisor ||
           mode_q[idx] != in_data.map_mode || pack_q[idx] != in_data.packing_code ||
           voff_q[idx] != in_data.vert_crop_word;
    job_d.changed = diff || sw;
    job_d.pts = ts_d;
    if (in_data.map_mode == vffcr_pkg::ModeHevcA || in_data.map_mode == vffcr_pkg::ModeTenBit)
    begin
      job_d.crop_width = in_data.pic_width - lc - rc;
      job_d.crop_height = in_data.pic_height - tc - bc;
    end else begin
      job_d.crop_width = in_data.pic_width - rc;
      job_d.crop_height = in_data.pic_height - bc;
    end
    job_d.numerator = in_data.rate_numerator;
    job_d.divisor = in_data.rate_divisor;
    job_d.live = in_data.clock_live;
    job_d.ten_bit = in_data.map_mode == vffcr_pkg::ModeTenBit;
    job_d.stereo = ($unsigned(in_data.packing_code) <= 8'd5) ?
                   3'(in_data.packing_code) + 3'd1 : 3'd0;
    job_d.voffset = in_data.vert_crop_word;
    job_d.aspect = {in_data.aspect_width, in_data.aspect_height};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= vffcr_pkg::NoChannel;
      dly_q <= 8'd0;
      ts_q <= 1'b0;
      job_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        wid_q[i] <= '0; hgt_q[i] <= '0; num_q[i] <= '0; div_q[i] <= '0;
        mode_q[i] <= vffcr_pkg::ModeReset; pack_q[i] <= '0; voff_q[i] <= '0;
      end
    end else begin
      // hold the job until the back takes it, refill on a new item
      if (take) begin
        job_valid_q <= 1'b1;
      end else if (job_ready_i) begin
        job_valid_q <= 1'b0;
      end
      if (take) begin
        prev_q <= prev_d;
        dly_q <= dly_d;
        ts_q <= ts_d;
        wid_q[idx] <= in_data.pic_width;
        hgt_q[idx] <= in_data.pic_height;
        num_q[idx] <= in_data.rate_numerator;
        div_q[idx] <= in_data.rate_divisor;
        mode_q[idx] <= in_data.map_mode;
        pack_q[idx] <= in_data.packing_code;
        voff_q[idx] <= in_data.vert_crop_word;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= job_d;
  end

  assign job_valid_o = job_valid_q;
  assign job_o = job_q;

  `VFR_ASSERT_IMP(a_hold, clk_i, rst_ni, job_valid_q && !job_ready_i, !in_ready)
  `VFR_ASSERT_IMP(a_prev, clk_i, rst_ni, 1'b1,
                  prev_q <= 3'd3 || prev_q == vffcr_pkg::NoChannel)
  `VFR_ASSERT_NEXT(a_off, clk_i, rst_ni, take && !seamless_i,
                   prev_q == vffcr_pkg::NoChannel && dly_q == 8'd0)
endmodule

// ===== sv/vffcr_back.sv =====
// Back part: serial rate divider, rate snapping and result register.
// Depends on vffcr_pkg.
`include "video_frame_format_change_reporter_core_macros.svh"
module vffcr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  vffcr_pkg::job_t      job_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vffcr_pkg::out_item_t out_data
);
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SNAP, S_OUT} state_e;
  state_e state_q;
  vffcr_pkg::job_t job_q;
  logic [41:0] quo_q;
  logic [32:0] rem_q;
  logic [41:0] dvd_q;
  logic [5:0]  cnt_q;
  logic [32:0] trial;
  logic [5:0]  rate;
  logic        err;
  vffcr_pkg::out_item_t res_q, res_d;

  assign job_ready_o = state_q == S_IDLE;
  assign trial = {rem_q[31:0], dvd_q[41]} - {1'b0, job_q.divisor};

  always_comb begin
    rate = vffcr_pkg::snap_rate(quo_q, job_q.live, err);
    if (job_q.divisor == 32'd0) begin
      rate = vffcr_pkg::ErrRate; err = 1'b1;
    end
    res_d = '0;
    res_d.pts_channel = job_q.pts;
    if (job_q.changed) begin
      res_d.format_changed = 1'b1;
      res_d.crop_width = job_q.crop_width;
      res_d.crop_height = job_q.crop_height;
      res_d.nominal_rate = rate;
      res_d.rate_error = err;
      res_d.ten_bit = job_q.ten_bit;
      res_d.stereo_type = job_q.stereo;
      res_d.vertical_offset = job_q.voffset;
      res_d.aspect_word = job_q.aspect;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      job_q <= '0;
      dvd_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      res_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (job_valid_i) begin
          job_q <= job_i;
          dvd_q <= 42'(job_i.numerator) * 42'd1000;
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= 6'd42;
          state_q <= job_i.changed ? S_DIV : S_SNAP;
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (!trial[32]) begin
            rem_q <= trial;
            quo_q <= {quo_q[40:0], 1'b1};
          end else begin
            rem_q <= {rem_q[31:0], dvd_q[41]};
            quo_q <= {quo_q[40:0], 1'b0};
          end
          dvd_q <= {dvd_q[40:0], 1'b0};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_q <= S_SNAP;
        end
        S_SNAP: begin
          res_q <= res_d;
          state_q <= S_OUT;
        end
        S_OUT: if (out_ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid = state_q == S_OUT;
  assign out_data = res_q;

  `VFR_ASSERT_IMP(a_cnt, clk_i, rst_ni, state_q == S_DIV, cnt_q != 6'd0)
  `VFR_ASSERT_IMP(a_quiet, clk_i, rst_ni, out_valid && !out_data.format_changed,
                  out_data.nominal_rate == 6'd0 && out_data.aspect_word == 32'd0)
  `VFR_ASSERT_NEXT(a_stall, clk_i, rst_ni, out_valid && !out_ready, out_valid)
endmodule

// ===== sv/video_frame_format_change_reporter_core.sv =====
// Video frame format change reporter, top level.
// Channels: in (valid/ready, one descriptor per item) and out (valid/ready,
// one result per item); the seamless flag is written through cfg_we/cfg_wdata.
// The front compares each descriptor with the stored state of its channel
// in the accept cycle and registers a job; that register is the queue to
// the back, so the next descriptor is taken as soon as the back takes the job.
// The back divides numerator*1000 by the divisor in a restoring divider,
// one quotient bit a cycle, then snaps the rate and registers the result;
// a job with no change skips the divider. The back is busy from taking a
// job until its result is accepted and takes no new job in that time.
// When out_ready is low the result holds, the back stays busy and
// the front stalls once its job register is full.
// Reset clears all per-channel state (map mode to five), the seamless
// tracking and the job register's valid flag; the block is ready in the first cycle.
module video_frame_format_change_reporter_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vffcr_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vffcr_pkg::out_item_t out_data
);
  logic seamless_q;
  logic job_valid, job_ready;
  vffcr_pkg::job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seamless_q <= 1'b0;
    else if (cfg_we) seamless_q <= cfg_wdata;
  end

  vffcr_front u_front (
    .clk_i, .rst_ni, .seamless_i(seamless_q), .in_valid, .in_ready, .in_data,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  vffcr_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .out_valid, .out_ready, .out_data
  );
endmodule
